// ===== rtl/core/amnt_pkg.sv =====
// amnt_pkg: shared types and constants of the ARP/IPv4 MAC translation table.
// Used by amnt_table and arp_mac_nat_table. No dependencies.
package amnt_pkg;

	localparam int unsigned MAC_W = 48;
	localparam int unsigned IP_W  = 32;
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned MCAST_BIT = 40;

	localparam logic       FUNC_OUTBOUND = 1'b1;
	localparam logic [1:0] KIND_ARP      = 2'd1;
	localparam logic [1:0] KIND_IPV4     = 2'd2;
	localparam logic [1:0] OP_REQUEST    = 2'd1;
	localparam logic [1:0] OP_REPLY      = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_OWN_IP       = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BRIDGE_MAC   = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_IN_PORT_MAC  = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_OUT_PORT_MAC = 8'd3;

	typedef struct packed {
		logic             func;
		logic [1:0]       frame_kind;
		logic [1:0]       arp_op;
		logic [MAC_W-1:0] dest_mac;
		logic [MAC_W-1:0] src_mac;
		logic [MAC_W-1:0] arp_sender_mac;
		logic [IP_W-1:0]  src_ip;
		logic [IP_W-1:0]  dst_ip;
	} frame_in_t;

	typedef struct packed {
		logic             drop;
		logic [MAC_W-1:0] new_dest_mac;
		logic [MAC_W-1:0] new_src_mac;
		logic             set_arp_target_mac;
		logic             set_arp_sender_mac;
		logic             other_host;
		logic             learn_failed;
	} verdict_t;

	typedef struct packed {
		logic             valid;
		logic [MAC_W-1:0] mac;
		logic [IP_W-1:0]  ip;
	} entry_t;

	// Outcome of one table walk
	typedef struct packed {
		logic             ip_hit;
		logic [MAC_W-1:0] ip_mac;
		logic             mac_hit;
		logic [IP_W-1:0]  mac_ip;
		logic             free_hit;
	} scan_res_t;

endpackage

// ===== rtl/core/amnt_table.sv =====
// amnt_table: pair memory with a clearing pass, one write port and a
// one-entry-per-cycle walk through a shared compare unit. Uses amnt_pkg.
module amnt_table import amnt_pkg::*; #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	output logic                       clearing,
	input  logic                       scan_start,
	input  logic [IP_W-1:0]            key_ip,
	input  logic [MAC_W-1:0]           key_mac,
	output logic                       scan_done,
	output scan_res_t                  res,
	output logic [$clog2(ENTRIES)-1:0] ip_idx,
	output logic [$clog2(ENTRIES)-1:0] mac_idx,
	output logic [$clog2(ENTRIES)-1:0] free_idx,
	input  logic                       wr_en,
	input  logic [$clog2(ENTRIES)-1:0] wr_idx,
	input  entry_t                     wr_entry
);
	localparam int unsigned IW = $clog2(ENTRIES);
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	entry_t mem [ENTRIES];
	entry_t rd_s1;

	logic          clearing_q;
	logic [IW-1:0] clr_cnt_q;
	logic          scanning_q;
	logic [IW-1:0] rd_cnt_q;
	logic          rd_v_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          done_q;
	logic [IP_W-1:0]  key_ip_q;
	logic [MAC_W-1:0] key_mac_q;
	scan_res_t     res_q;
	logic [IW-1:0] ip_idx_q, mac_idx_q, free_idx_q;

	logic hit_ip, hit_mac, hit_free;

	always_ff @(posedge clk) begin
		if (clearing_q)
			mem[clr_cnt_q] <= '0;
		else if (wr_en)
			mem[wr_idx] <= wr_entry;
		rd_s1 <= mem[rd_cnt_q];
	end

	always_ff @(posedge clk) begin
		if (scan_start) begin
			key_ip_q  <= key_ip;
			key_mac_q <= key_mac;
		end
	end

	// shared compare unit
	assign hit_ip   = rd_v_s1 && rd_s1.valid && (rd_s1.ip == key_ip_q);
	assign hit_mac  = rd_v_s1 && rd_s1.valid && (rd_s1.mac == key_mac_q);
	assign hit_free = rd_v_s1 && !rd_s1.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			scanning_q <= 1'b0;
			rd_cnt_q   <= '0;
			rd_v_s1    <= 1'b0;
			rd_idx_s1  <= '0;
			done_q     <= 1'b0;
			res_q      <= '0;
			ip_idx_q   <= '0;
			mac_idx_q  <= '0;
			free_idx_q <= '0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == LAST)
					clearing_q <= 1'b0;
			end
			if (scan_start) begin
				scanning_q <= 1'b1;
				rd_cnt_q   <= '0;
			end else if (scanning_q) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
				if (rd_cnt_q == LAST)
					scanning_q <= 1'b0;
			end
			rd_v_s1   <= scanning_q && !scan_start;
			rd_idx_s1 <= rd_cnt_q;
			done_q    <= rd_v_s1 && (rd_idx_s1 == LAST);
			if (scan_start) begin
				res_q <= '0;
			end else begin
				// first hit wins
				if (hit_ip && !res_q.ip_hit) begin
					res_q.ip_hit <= 1'b1;
					res_q.ip_mac <= rd_s1.mac;
					ip_idx_q     <= rd_idx_s1;
				end
				if (hit_mac && !res_q.mac_hit) begin
					res_q.mac_hit <= 1'b1;
					res_q.mac_ip  <= rd_s1.ip;
					mac_idx_q     <= rd_idx_s1;
				end
				if (hit_free && !res_q.free_hit) begin
					res_q.free_hit <= 1'b1;
					free_idx_q     <= rd_idx_s1;
				end
			end
		end
	end

	assign clearing  = clearing_q;
	assign scan_done = done_q;
	assign res       = res_q;
	assign ip_idx    = ip_idx_q;
	assign mac_idx   = mac_idx_q;
	assign free_idx  = free_idx_q;

endmodule

// ===== rtl/core/arp_mac_nat_table.sv =====
// Each frame is walked through the whole table before its verdict; a learning frame then
// takes up to two table writes (wipe, store) before the verdict is offered.
// One frame at a time: no new frame is taken until the verdict is transferred. The walk
// reads one entry per cycle through one read port and one shared compare unit.
// Reset: asynchronous, active low; then a clearing pass over all TABLE_ENTRIES entries during
// which no frame is taken (configuration writes are taken). Uses amnt_pkg, amnt_table.
module arp_mac_nat_table import amnt_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  frame_in_t              in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output verdict_t               out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [MAC_W-1:0]       cfg_data
);
	localparam int unsigned IW = $clog2(TABLE_ENTRIES);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WIPE, S_WRITE, S_OUT} state_t;

	state_t state_q;

	// configuration registers
	logic [IP_W-1:0]  own_ip_q;
	logic [MAC_W-1:0] bridge_mac_q, in_port_mac_q, out_port_mac_q;

	// frame under work, plan and verdict
	frame_in_t     item_q;
	verdict_t      out_q;
	logic          out_valid_q;
	logic          write_q;
	logic [IW-1:0] slot_q;

	// table interface
	logic          clearing, scan_start, scan_done, wr_en;
	scan_res_t     res;
	logic [IW-1:0] ip_idx, mac_idx, free_idx, wr_idx;
	logic [IP_W-1:0]  key_ip;
	logic [MAC_W-1:0] key_mac;
	entry_t        wr_entry;

	// decision
	verdict_t      v;
	logic          learn, do_wipe, do_write;
	logic [IW-1:0] slot;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q       <= '0;
			bridge_mac_q   <= '0;
			in_port_mac_q  <= '0;
			out_port_mac_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OWN_IP:       own_ip_q       <= cfg_data[IP_W-1:0];
				CFG_BRIDGE_MAC:   bridge_mac_q   <= cfg_data;
				CFG_IN_PORT_MAC:  in_port_mac_q  <= cfg_data;
				CFG_OUT_PORT_MAC: out_port_mac_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Walk keys: outbound frames look up their sender pair, inbound ones
	// their destination IP and destination MAC.
	assign in_ready   = (state_q == S_IDLE) && !clearing;
	assign scan_start = in_valid && in_ready;
	always_comb begin
		if (in_data.func == FUNC_OUTBOUND) begin
			key_ip  = in_data.src_ip;
			key_mac = (in_data.frame_kind == KIND_ARP) ? in_data.arp_sender_mac
			                                           : in_data.src_mac;
		end else begin
			key_ip  = in_data.dst_ip;
			key_mac = in_data.dest_mac;
		end
	end

	amnt_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.clearing   (clearing),
		.scan_start (scan_start),
		.key_ip     (key_ip),
		.key_mac    (key_mac),
		.scan_done  (scan_done),
		.res        (res),
		.ip_idx     (ip_idx),
		.mac_idx    (mac_idx),
		.free_idx   (free_idx),
		.wr_en      (wr_en),
		.wr_idx     (wr_idx),
		.wr_entry   (wr_entry)
	);

	// Verdict and learning plan, valid once the walk is done.
	always_comb begin
		logic is_arp, is_ip, rr, mc, dip_own, sip_own, done;
		is_arp  = (item_q.frame_kind == KIND_ARP);
		is_ip   = (item_q.frame_kind == KIND_IPV4);
		rr      = (item_q.arp_op == OP_REQUEST) || (item_q.arp_op == OP_REPLY);
		mc      = item_q.dest_mac[MCAST_BIT];
		dip_own = (item_q.dst_ip == own_ip_q);
		sip_own = (item_q.src_ip == own_ip_q);
		done    = 1'b0;

		v = '0;
		v.new_dest_mac = item_q.dest_mac;
		v.new_src_mac  = item_q.src_mac;

		learn = 1'b0;
		if (item_q.func == FUNC_OUTBOUND) begin
			if (is_arp && rr) begin
				learn = !dip_own && !sip_own;
				if (!dip_own) begin
					v.new_src_mac        = out_port_mac_q;
					v.set_arp_sender_mac = 1'b1;
				end
			end else begin
				learn = is_ip && !sip_own && !res.ip_hit;
				v.new_src_mac = out_port_mac_q;
			end
		end else begin
			if (is_arp) begin
				if (dip_own) begin
					done = 1'b1;
				end else if (rr && res.ip_hit) begin
					if (!mc) begin
						v.new_dest_mac       = res.ip_mac;
						v.set_arp_target_mac = 1'b1;
						v.other_host         = 1'b1;
					end
					done = 1'b1;
				end
			end else if (is_ip && !mc && res.ip_hit) begin
				if (dip_own) begin
					v.new_dest_mac = bridge_mac_q;
				end else begin
					v.new_dest_mac = res.ip_mac;
					v.other_host   = 1'b1;
				end
				done = 1'b1;
			end
			// unicast check
			if (!done && !mc) begin
				if (item_q.dest_mac != bridge_mac_q && item_q.dest_mac != in_port_mac_q)
					v.drop = 1'b1;
				else if (!res.mac_hit)
					v.new_dest_mac = bridge_mac_q;
			end
		end

		// Known MAC: retarget it if its IP moved. New MAC: lowest free slot,
		// counting the slot freed by the wipe.
		if (res.mac_hit) begin
			do_write = learn && (res.mac_ip != item_q.src_ip);
			do_wipe  = do_write && res.ip_hit;
			slot     = mac_idx;
		end else begin
			do_write = learn && (res.ip_hit || res.free_hit);
			do_wipe  = learn && res.ip_hit;
			slot     = (res.ip_hit && !(res.free_hit && free_idx < ip_idx)) ? ip_idx
			                                                               : free_idx;
		end
		v.learn_failed = learn && !res.mac_hit && !res.ip_hit && !res.free_hit;
	end

	// Sequencer: walk, up to two table writes, then hold the verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			write_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (scan_start)
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_done) begin
						write_q <= do_write;
						if (do_wipe) begin
							state_q <= S_WIPE;
						end else if (do_write) begin
							state_q <= S_WRITE;
						end else begin
							state_q     <= S_OUT;
							out_valid_q <= 1'b1;
						end
					end
				end
				S_WIPE: begin
					if (write_q) begin
						state_q <= S_WRITE;
					end else begin
						state_q     <= S_OUT;
						out_valid_q <= 1'b1;
					end
				end
				S_WRITE: begin
					state_q     <= S_OUT;
					out_valid_q <= 1'b1;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (scan_start)
			item_q <= in_data;
		if (state_q == S_SCAN && scan_done) begin
			out_q  <= v;
			slot_q <= slot;
		end
	end

	// table write port: wipe clears the entry holding the new IP
	assign wr_en  = (state_q == S_WIPE) || (state_q == S_WRITE);
	assign wr_idx = (state_q == S_WIPE) ? ip_idx : slot_q;
	always_comb begin
		wr_entry = '0;
		if (state_q == S_WRITE) begin
			wr_entry.valid = 1'b1;
			wr_entry.mac   = (item_q.frame_kind == KIND_ARP) ? item_q.arp_sender_mac
			                                                 : item_q.src_mac;
			wr_entry.ip    = item_q.src_ip;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a verdict is pending");

	a_fail_outbound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.learn_failed) |-> (item_q.func == FUNC_OUTBOUND))
		else $error("learn failure flagged on an inbound frame");

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> (state_q == S_SCAN))
		else $error("table walk finished outside the walk state");

	a_write_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WIPE) |-> $past(state_q == S_SCAN))
		else $error("wipe not directly after the walk");
`endif

endmodule
